// ===== rtl/qes_pkg.sv =====
package qes_pkg;

  // Case of one coefficient word, settled at the input and refined once d is known.
  typedef enum logic [2:0] {
    K_ZERO,
    K_NONE,
    K_LIN,
    K_BZERO,
    K_GEN
  } kind_t;

  // Control travelling beside the data through every stage.
  typedef struct packed {
    logic  vld;
    kind_t kind;
    logic  sa;
    logic  sb;
    logic  sc;
  } flags_t;

  localparam logic [1:0] ST_TWO  = 2'd0;
  localparam logic [1:0] ST_LIN  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam int ROOT_W = 34;

endpackage

// ===== rtl/quadratic_equation_solver.sv =====
// Channel   Direction  Ports                                          Handshake
// in        input      in_coef_a, in_coef_b, in_coef_c                in_valid / in_stall
// out       output     out_status, out_root_first, out_root_second    out_valid / out_stall
//
// A new coefficient word is taken in every cycle while in_stall is low; each word gives exactly
// one result word. The pipeline has one divider cell and one square-root cell per quotient and
// root bit, three stages that square h and form d, one stage that forms the roots, and the
// output register.
// Reset is synchronous and active low; it empties the pipeline and the output register.
// The whole pipeline holds while a result waits in the output register under out_stall.
module quadratic_equation_solver #(
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COEF_WIDTH-1:0]        in_coef_a,
  input  logic [COEF_WIDTH-1:0]        in_coef_b,
  input  logic [COEF_WIDTH-1:0]        in_coef_c,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [qes_pkg::ROOT_W-1:0]   out_root_first,
  output logic [qes_pkg::ROOT_W-1:0]   out_root_second
);

  // Quotients and the root both carry N bits; the radicand of d has 2N.
  localparam int W  = COEF_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int N  = W + F;
  localparam int DV = W + 1;
  localparam int D  = 2 * N;
  localparam int RW = N + 2;
  localparam int L  = (N + 1) / 2;
  localparam int HI = N - L;
  localparam int XW = (N + 3 > qes_pkg::ROOT_W + 1) ? N + 3 : qes_pkg::ROOT_W + 1;
  localparam logic signed [XW-1:0] RMAX =
    {{(XW - qes_pkg::ROOT_W + 1){1'b0}}, {(qes_pkg::ROOT_W - 1){1'b1}}};
  localparam logic signed [XW-1:0] RMIN = ~RMAX;

  logic en;

  // The pipeline advances unless the output register is full and held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input decode: signs, magnitudes and the case of the word.
  logic           sa, sb, sc;
  logic [W-1:0]   a_mag, b_mag, c_mag;
  logic           a_zero, b_zero, c_zero;
  qes_pkg::flags_t fl_in;

  always_comb begin
    sa     = in_coef_a[W-1];
    sb     = in_coef_b[W-1];
    sc     = in_coef_c[W-1];
    a_mag  = sa ? (~in_coef_a + 1'b1) : in_coef_a;
    b_mag  = sb ? (~in_coef_b + 1'b1) : in_coef_b;
    c_mag  = sc ? (~in_coef_c + 1'b1) : in_coef_c;
    a_zero = (in_coef_a == '0);
    b_zero = (in_coef_b == '0);
    c_zero = (in_coef_c == '0);
    fl_in.vld = in_valid;
    fl_in.sa  = sa;
    fl_in.sb  = sb;
    fl_in.sc  = sc;
    if (a_zero && b_zero) begin
      fl_in.kind = c_zero ? qes_pkg::K_ZERO : qes_pkg::K_NONE;
    end else if (a_zero) begin
      fl_in.kind = qes_pkg::K_LIN;
    end else if (b_zero) begin
      fl_in.kind = qes_pkg::K_BZERO;
    end else begin
      fl_in.kind = qes_pkg::K_GEN;
    end
  end

  // Two divider lanes run side by side. Lane h gives |b|/(2|a|); lane q gives |c|/|a|,
  // or |c|/|b| when the equation is linear.
  logic [DV-1:0] h_rem [N+1];
  logic [N-1:0]  h_num [N+1];
  logic [N-1:0]  h_quo [N+1];
  logic [DV-1:0] h_dvs [N+1];
  logic [DV-1:0] q_rem [N+1];
  logic [N-1:0]  q_num [N+1];
  logic [N-1:0]  q_quo [N+1];
  logic [DV-1:0] q_dvs [N+1];

  assign h_rem[0] = '0;
  assign h_num[0] = {b_mag, {F{1'b0}}};
  assign h_quo[0] = '0;
  assign h_dvs[0] = {a_mag, 1'b0};
  assign q_rem[0] = '0;
  assign q_num[0] = {c_mag, {F{1'b0}}};
  assign q_quo[0] = '0;
  assign q_dvs[0] = (fl_in.kind == qes_pkg::K_LIN) ? {1'b0, b_mag} : {1'b0, a_mag};

  qes_pkg::flags_t fl_div_r [N];

  for (genvar k = 0; k < N; k++) begin : g_div
    qes_div_cell #(.NW(N), .DV(DV)) u_hcell (
      .clk(clk), .en(en),
      .rem_i(h_rem[k]), .num_i(h_num[k]), .quo_i(h_quo[k]), .dvs_i(h_dvs[k]),
      .rem_o(h_rem[k+1]), .num_o(h_num[k+1]), .quo_o(h_quo[k+1]), .dvs_o(h_dvs[k+1])
    );
    qes_div_cell #(.NW(N), .DV(DV)) u_qcell (
      .clk(clk), .en(en),
      .rem_i(q_rem[k]), .num_i(q_num[k]), .quo_i(q_quo[k]), .dvs_i(q_dvs[k]),
      .rem_o(q_rem[k+1]), .num_o(q_num[k+1]), .quo_o(q_quo[k+1]), .dvs_o(q_dvs[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) fl_div_r[i] <= '0;
    end else if (en) begin
      fl_div_r[0] <= fl_in;
      for (int i = 1; i < N; i++) fl_div_r[i] <= fl_div_r[i-1];
    end
  end

  // h squared is built from three half-width partial products, then summed.
  logic [N-1:0]      hm, qm;
  logic [2*HI-1:0]   pp_hh_r;
  logic [HI+L-1:0]   pp_hl_r;
  logic [2*L-1:0]    pp_ll_r;
  logic [N-1:0]      hm_m1_r, qm_m1_r;
  qes_pkg::flags_t   fl_m1_r;

  assign hm = h_quo[N];
  assign qm = q_quo[N];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= hm[N-1:L] * hm[N-1:L];
      pp_hl_r <= hm[N-1:L] * hm[L-1:0];
      pp_ll_r <= hm[L-1:0] * hm[L-1:0];
      hm_m1_r <= hm;
      qm_m1_r <= qm;
    end
  end

  logic [D-1:0]    h2_m2_r;
  logic [N-1:0]    hm_m2_r, qm_m2_r;
  qes_pkg::flags_t fl_m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h2_m2_r <= (D'(pp_hh_r) << (2 * L)) + (D'(pp_hl_r) << (L + 1)) + D'(pp_ll_r);
      hm_m2_r <= hm_m1_r;
      qm_m2_r <= qm_m1_r;
    end
  end

  // d = h^2 - q, with q scaled to 2F fraction bits. A negative d, or a negative
  // nonzero r when b is zero, leaves no real root. The radicand for b zero is r << F.
  logic [D-1:0]    qs;
  logic [D-1:0]    rad_sel;
  logic [N-1:0]    tag_sel;
  qes_pkg::flags_t fl_m3;
  logic [D-1:0]    rad_m3_r;
  logic [N-1:0]    tag_m3_r;
  qes_pkg::flags_t fl_m3_r;

  always_comb begin
    qs      = D'(qm_m2_r) << F;
    fl_m3   = fl_m2_r;
    rad_sel = D'(qm_m2_r) << F;
    tag_sel = (fl_m2_r.kind == qes_pkg::K_LIN) ? qm_m2_r : hm_m2_r;
    case (fl_m2_r.kind)
      qes_pkg::K_GEN: begin
        if (fl_m2_r.sc != fl_m2_r.sa) begin
          rad_sel = h2_m2_r + qs;
        end else if (h2_m2_r < qs) begin
          fl_m3.kind = qes_pkg::K_NONE;
        end else begin
          rad_sel = h2_m2_r - qs;
        end
      end
      qes_pkg::K_BZERO: begin
        if ((qm_m2_r != '0) && (fl_m2_r.sc == fl_m2_r.sa)) begin
          fl_m3.kind = qes_pkg::K_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_m3_r <= rad_sel;
      tag_m3_r <= tag_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_m1_r <= '0;
      fl_m2_r <= '0;
      fl_m3_r <= '0;
    end else if (en) begin
      fl_m1_r <= fl_div_r[N-1];
      fl_m2_r <= fl_m1_r;
      fl_m3_r <= fl_m3;
    end
  end

  // Square-root chain, one root bit per cell; the tag carries h, or the linear quotient.
  logic [D-1:0]  s_rad  [N+1];
  logic [RW-1:0] s_rem  [N+1];
  logic [N-1:0]  s_root [N+1];
  logic [N-1:0]  s_tag  [N+1];

  assign s_rad[0]  = rad_m3_r;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_tag[0]  = tag_m3_r;

  qes_pkg::flags_t fl_sq_r [N];

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    qes_sqrt_cell #(.RADW(D), .ROOTW(N), .TAGW(N)) u_scell (
      .clk(clk), .en(en),
      .rad_i(s_rad[k]), .rem_i(s_rem[k]), .root_i(s_root[k]), .tag_i(s_tag[k]),
      .rad_o(s_rad[k+1]), .rem_o(s_rem[k+1]), .root_o(s_root[k+1]), .tag_o(s_tag[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) fl_sq_r[i] <= '0;
    end else if (en) begin
      fl_sq_r[0] <= fl_m3_r;
      for (int i = 1; i < N; i++) fl_sq_r[i] <= fl_sq_r[i-1];
    end
  end

  // Roots in a wide signed form; saturation follows in the output register.
  qes_pkg::flags_t         fl_last;
  logic signed [XW-1:0]    sx, tx, hx, r1, r2;
  logic [1:0]              st;
  logic signed [XW-1:0]    r1_f_r, r2_f_r;
  logic [1:0]              st_f_r;
  logic                    vld_f_r;

  always_comb begin
    fl_last = fl_sq_r[N-1];
    sx      = $signed(XW'(s_root[N]));
    tx      = $signed(XW'(s_tag[N]));
    hx      = (fl_last.sb != fl_last.sa) ? -tx : tx;
    r1      = '0;
    r2      = '0;
    case (fl_last.kind)
      qes_pkg::K_ZERO: begin
        st = qes_pkg::ST_ZERO;
      end
      qes_pkg::K_LIN: begin
        st = qes_pkg::ST_LIN;
        r1 = (fl_last.sc == fl_last.sb) ? -tx : tx;
      end
      qes_pkg::K_BZERO: begin
        st = qes_pkg::ST_TWO;
        r1 = sx;
        r2 = -sx;
      end
      qes_pkg::K_GEN: begin
        st = qes_pkg::ST_TWO;
        r1 = sx - hx;
        r2 = -sx - hx;
      end
      default: begin
        st = qes_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_f_r <= r1;
      r2_f_r <= r2;
      st_f_r <= st;
    end
  end

  function automatic logic [qes_pkg::ROOT_W-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    c = (v > RMAX) ? RMAX : ((v < RMIN) ? RMIN : v);
    return c[qes_pkg::ROOT_W-1:0];
  endfunction

  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [qes_pkg::ROOT_W-1:0]   out_root_first_r, out_root_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_f_r     <= fl_last.vld;
      out_valid_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r      <= st_f_r;
      out_root_first_r  <= sat(r1_f_r);
      out_root_second_r <= sat(r2_f_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_root_first  = out_root_first_r;
  assign out_root_second = out_root_second_r;

  // A word with no real root, or all coefficients zero, never carries a nonzero root.
  a_noroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qes_pkg::ST_NONE || out_status == qes_pkg::ST_ZERO)
      |-> (out_root_first == '0) && (out_root_second == '0))
    else $error("root given without a real root");

  // The linear case has one root only.
  a_lin_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qes_pkg::ST_LIN) |-> (out_root_second == '0))
    else $error("second root set in linear case");

  // With two roots the first is +sqrt and never below the second.
  a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qes_pkg::ST_TWO)
      |-> ($signed(out_root_first) >= $signed(out_root_second)))
    else $error("roots out of order");

endmodule

// ===== rtl/qes_div_cell.sv =====
module qes_div_cell #(
  parameter int NW = 32,
  parameter int DV = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DV-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  input  logic [DV-1:0] dvs_i,
  output logic [DV-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [DV-1:0] dvs_o
);

  logic [DV:0]   trial;
  logic [DV:0]   diff;
  logic          ge;
  logic [DV-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial   = {rem_i, num_i[NW-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = (trial >= {1'b0, dvs_i});
    rem_nxt = ge ? diff[DV-1:0] : trial[DV-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      num_o <= {num_i[NW-2:0], 1'b0};
      quo_o <= {quo_i[NW-2:0], ge};
      dvs_o <= dvs_i;
    end
  end

endmodule

// ===== rtl/qes_sqrt_cell.sv =====
module qes_sqrt_cell #(
  parameter int RADW  = 64,
  parameter int ROOTW = 32,
  parameter int TAGW  = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RADW-1:0]    rad_i,
  input  logic [ROOTW+1:0]   rem_i,
  input  logic [ROOTW-1:0]   root_i,
  input  logic [TAGW-1:0]    tag_i,
  output logic [RADW-1:0]    rad_o,
  output logic [ROOTW+1:0]   rem_o,
  output logic [ROOTW-1:0]   root_o,
  output logic [TAGW-1:0]    tag_o
);

  logic [ROOTW+3:0] cur;
  logic [ROOTW+3:0] trial;
  logic [ROOTW+3:0] diff;
  logic             ge;

  // One root bit per cell: two radicand bits come down, trial is 4*root+1.
  always_comb begin
    cur   = {rem_i, rad_i[RADW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = cur - trial;
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[RADW-3:0], 2'b00};
      rem_o  <= ge ? diff[ROOTW+1:0] : cur[ROOTW+1:0];
      root_o <= {root_i[ROOTW-2:0], ge};
      tag_o  <= tag_i;
    end
  end

endmodule

// ===== tb/quadratic_equation_solver_test.sv =====
`timescale 1ns / 1ps

module quadratic_equation_solver_test;

  localparam int FRAC    = 16;
  localparam int CW      = 16;
  localparam int LATENCY = 2 * (CW + FRAC) + 5;
  // Watchdog: cycles in a row with no word accepted on either side.
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;

  typedef struct packed {
    logic [1:0]                 status;
    logic [qes_pkg::ROOT_W-1:0] root_first;
    logic [qes_pkg::ROOT_W-1:0] root_second;
  } roots_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CW-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [qes_pkg::ROOT_W-1:0] out_root_first, out_root_second;

  roots_t expected_roots[$];
  int unsigned error_count;
  int unsigned idle_cycles;

  quadratic_equation_solver u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_root_first (out_root_first),
    .out_root_second(out_root_second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root by bit-by-bit trial; the operand fits in 128 bits.
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
      t = r | (64'd1 << bit_idx);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Clamp a signed root to the 34-bit output range.
  function automatic logic [qes_pkg::ROOT_W-1:0] saturate(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (qes_pkg::ROOT_W - 1)) - 1;
    lo = -(128'sd1 <<< (qes_pkg::ROOT_W - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[qes_pkg::ROOT_W-1:0];
  endfunction

  // Predicts the status and both roots for one set of coefficients.
  function automatic roots_t solve_roots(logic [CW-1:0] ra, logic [CW-1:0] rb,
                                         logic [CW-1:0] rc);
    roots_t res;
    logic signed [CW-1:0] a, b, c;
    logic [63:0] ma, mb, mc, m, hm, qm, s;
    logic [127:0] h2, qs, d;
    logic signed [127:0] h, r1, r2;
    a = ra;
    b = rb;
    c = rc;
    ma = a[CW-1] ? 64'(-64'(a)) : 64'(a);
    mb = b[CW-1] ? 64'(-64'(b)) : 64'(b);
    mc = c[CW-1] ? 64'(-64'(c)) : 64'(c);
    res.status = qes_pkg::ST_NONE;
    r1 = 0;
    r2 = 0;
    if (a == 0 && b == 0) begin
      res.status = (c == 0) ? qes_pkg::ST_ZERO : qes_pkg::ST_NONE;
    end else if (a == 0) begin
      // Linear root -c/b, magnitude truncated toward zero.
      m = (mc << FRAC) / mb;
      r1 = ((c < 0) != (b < 0)) ? 128'sd0 + m : -(128'sd0 + m);
      res.status = qes_pkg::ST_LIN;
    end else if (b == 0) begin
      // r = -c/a; a truncated zero counts as a double root at zero.
      m = (mc << FRAC) / ma;
      if (m != 0 && ((c < 0) == (a < 0))) begin
        res.status = qes_pkg::ST_NONE;
      end else begin
        s = isqrt({64'd0, m} << FRAC);
        r1 = 128'sd0 + s;
        r2 = -(128'sd0 + s);
        res.status = qes_pkg::ST_TWO;
      end
    end else begin
      hm = (mb << FRAC) / (ma << 1);
      qm = (mc << FRAC) / ma;
      h2 = {64'd0, hm} * {64'd0, hm};
      qs = {64'd0, qm} << FRAC;
      if ((c < 0) != (a < 0) || h2 >= qs) begin
        d = ((c < 0) != (a < 0)) ? h2 + qs : h2 - qs;
        s = isqrt(d);
        h = ((b < 0) != (a < 0)) ? -(128'sd0 + hm) : 128'sd0 + hm;
        r1 = (128'sd0 + s) - h;
        r2 = -(128'sd0 + s) - h;
        res.status = qes_pkg::ST_TWO;
      end
    end
    res.root_first = saturate(r1);
    res.root_second = saturate(r2);
    return res;
  endfunction

  task automatic report(string what, logic [qes_pkg::ROOT_W-1:0] got,
                        logic [qes_pkg::ROOT_W-1:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one coefficient word after a random gap and records its prediction.
  // With no gap the word follows the previous one directly, so valid stays high.
  task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    expected_roots = {expected_roots, solve_roots(a, b, c)};
    do @(posedge clk); while (in_stall);
  endtask

  // Checks each result word against the oldest prediction.
  initial begin : result_checker
    roots_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          report("result word with nothing expected", out_root_first, '0);
        end else begin
          want = expected_roots.pop_front();
          if (out_status !== want.status)
            report("status", qes_pkg::ROOT_W'(out_status), qes_pkg::ROOT_W'(want.status));
          if (out_root_first !== want.root_first)
            report("root_first", out_root_first, want.root_first);
          if (out_root_second !== want.root_second)
            report("root_second", out_root_second, want.root_second);
        end
      end
    end
  end

  // The receiver stalls for a random number of cycles per result word, with calm stretches.
  initial begin : sink_stall
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 3);
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [CW-1:0] edge_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return CW'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Directed words: extremes and every case that the status field can report.
  task automatic test_directed();
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd0, 16'd0, 16'd5);
    send_coefs(16'd0, 16'd0, 16'h8000);
    send_coefs(16'd0, 16'd3, 16'd7);
    send_coefs(16'd0, 16'hFFFD, 16'd7);
    send_coefs(16'd0, 16'd1, 16'h8000);
    send_coefs(16'd0, 16'hFFFF, 16'h8000);
    send_coefs(16'd0, 16'h8000, 16'h7FFF);
    send_coefs(16'd1, 16'd0, 16'hFFFC);
    send_coefs(16'd1, 16'd0, 16'd4);
    send_coefs(16'h7FFF, 16'd0, 16'd1);
    send_coefs(16'hFFFF, 16'd0, 16'h7FFF);
    send_coefs(16'h8000, 16'd0, 16'h8000);
    send_coefs(16'd1, 16'hFFFD, 16'd2);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'd1, 16'd1);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h7FFF, 16'h7FFF);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_coefs(16'hFFFF, 16'h8000, 16'h7FFF);
    send_coefs(16'h8000, 16'd1, 16'h7FFF);
    send_coefs(16'h7FFF, 16'd1, 16'h8000);
  endtask

  // Random words weighted toward the zero-coefficient cases and factorable equations.
  task automatic test_random(int count);
    logic [CW-1:0] a, b, c;
    int r1, r2, k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin a = '0; b = CW'($urandom); c = CW'($urandom); end
        1: begin a = CW'($urandom); b = '0; c = CW'($urandom); end
        2: begin a = edge_value(); b = edge_value(); c = edge_value(); end
        3, 4: begin
          // k*(x-r1)*(x-r2) with small integer roots.
          k = $urandom_range(1, 8);
          r1 = $urandom_range(0, 40) - 20;
          r2 = $urandom_range(0, 40) - 20;
          a = CW'(k);
          b = CW'(-k * (r1 + r2));
          c = CW'(k * r1 * r2);
          if ($urandom_range(0, 1)) begin a = -a; b = -b; c = -c; end
        end
        5: begin
          a = CW'($urandom_range(0, 15) - 8);
          b = CW'($urandom);
          c = CW'($urandom);
        end
        default: begin a = CW'($urandom); b = CW'($urandom); c = CW'($urandom); end
      endcase
      send_coefs(a, b, c);
    end
  endtask

  initial begin : main_sequence
    error_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(600);
    in_valid <= 1'b0;

    // Drain: every word gives a result, so wait for the queue, then a latency more.
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
